>>> rtl/fatlb_pkg.sv
// ----------------------------------------------------------------------------
// fatlb_pkg
// Shared types and constants of the fully associative translation buffer:
// command codes, fixed field widths and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package fatlb_pkg;

  localparam int CMD_W   = 2;
  localparam int STAMP_W = 64;
  localparam int COUNT_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture the request beat
    logic exec;        // lookup / insert into free slot / flush
    logic scan_clear;  // arm the victim scan
    logic scan_step;   // advance the victim scan
    logic evict;       // replace the chosen victim
    logic resp;        // load the response register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;   // insert with every slot valid
    logic scan_done;   // last stamp compared this cycle
    logic out_free;    // response register can take a beat
  } dp_status_t;

endpackage

>>> rtl/fatlb_ifs.sv
// ----------------------------------------------------------------------------
// fatlb request / response channels
// Valid/ready channels carrying one command beat in and one result beat out.
// ----------------------------------------------------------------------------
interface fatlb_req_if #(
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 20
);
  logic                        valid;
  logic                        ready;
  logic [fatlb_pkg::CMD_W-1:0] cmd;
  logic [PAGE_BITS-1:0]        vpn;
  logic [FRAME_BITS-1:0]       frame_in;

  modport source (output valid, output cmd, output vpn, output frame_in, input ready);
  modport sink   (input valid, input cmd, input vpn, input frame_in, output ready);
endinterface

interface fatlb_rsp_if #(
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 20
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [FRAME_BITS-1:0]         frame_out;
  logic                          evicted;
  logic [PAGE_BITS-1:0]          evicted_vpn;
  logic [fatlb_pkg::COUNT_W-1:0] hit_count;
  logic [fatlb_pkg::COUNT_W-1:0] miss_count;
  logic [fatlb_pkg::COUNT_W-1:0] eviction_count;

  modport source (output valid, output hit, output frame_out, output evicted,
                  output evicted_vpn, output hit_count, output miss_count,
                  output eviction_count, input ready);
  modport sink   (input valid, input hit, input frame_out, input evicted,
                  input evicted_vpn, input hit_count, input miss_count,
                  input eviction_count, output ready);
endinterface

>>> rtl/fatlb_ctl.sv
// ----------------------------------------------------------------------------
// fatlb_ctl
// Command sequencer: accept, execute, optional victim scan and replace,
// then hand the result to the response register.
// ----------------------------------------------------------------------------
module fatlb_ctl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fatlb_pkg::dp_status_t status,
  output fatlb_pkg::ctl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.need_scan) begin
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_RESP;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) state_next = S_EVICT;
      end
      S_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        // hold until the response register drains
        if (status.out_free) begin
          cmd.resp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

>>> rtl/fatlb_dp.sv
// ----------------------------------------------------------------------------
// fatlb_dp
// Entry storage, parallel page compare, stamp scan for the oldest entry,
// access clock, statistics counters and the response register.
// ----------------------------------------------------------------------------
module fatlb_dp #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fatlb_pkg::CMD_W-1:0]   in_cmd,
  input  logic [PAGE_BITS-1:0]          in_vpn,
  input  logic [FRAME_BITS-1:0]         in_frame,
  input  fatlb_pkg::ctl_cmd_t           ctl,
  output fatlb_pkg::dp_status_t         status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [FRAME_BITS-1:0]         out_pfn,
  output logic                          out_evicted,
  output logic [PAGE_BITS-1:0]          out_evicted_vpn,
  output logic [fatlb_pkg::COUNT_W-1:0] out_hit_count,
  output logic [fatlb_pkg::COUNT_W-1:0] out_miss_count,
  output logic [fatlb_pkg::COUNT_W-1:0] out_eviction_count
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // captured request
  logic [fatlb_pkg::CMD_W-1:0] cmd_q;
  logic [PAGE_BITS-1:0]        vpn_q;
  logic [FRAME_BITS-1:0]       frame_q;

  // entry state
  logic [ENTRIES-1:0]             valid;
  logic [PAGE_BITS-1:0]           page_q [ENTRIES];
  logic [FRAME_BITS-1:0]          frame_mem [ENTRIES];
  logic [fatlb_pkg::STAMP_W-1:0]  stamp_mem [ENTRIES];
  logic [fatlb_pkg::STAMP_W-1:0]  access_clock;
  logic [fatlb_pkg::STAMP_W-1:0]  clock_inc;

  logic [fatlb_pkg::COUNT_W-1:0] hits_total;
  logic [fatlb_pkg::COUNT_W-1:0] misses_total;
  logic [fatlb_pkg::COUNT_W-1:0] evictions_total;

  // compare results
  logic [ENTRIES-1:0] match;
  logic               hit_any;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      free_idx;
  logic               all_valid;

  // memory write ports
  logic                          st_we;
  logic [IW-1:0]                 st_waddr;
  logic [fatlb_pkg::STAMP_W-1:0] st_wdata;
  logic                          fr_we;
  logic [IW-1:0]                 fr_waddr;
  logic                          pg_we;
  logic [IW-1:0]                 pg_waddr;

  // read data
  logic [FRAME_BITS-1:0]         frame_rd;
  logic [fatlb_pkg::STAMP_W-1:0] stamp_rd;

  // victim scan
  logic                          rd_active;
  logic [IW-1:0]                 rd_ptr;
  logic                          cmp_valid;
  logic [IW-1:0]                 cmp_idx;
  logic [fatlb_pkg::STAMP_W-1:0] best;
  logic [IW-1:0]                 victim;

  // result flags
  logic                 hit_flag;
  logic                 evict_flag;
  logic [PAGE_BITS-1:0] evicted_vpn_q;

  assign clock_inc = access_clock + fatlb_pkg::STAMP_W'(1);

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      match[k] = valid[k] && (page_q[k] == vpn_q);
      if (match[k])  hit_idx  = IW'(k);
      if (!valid[k]) free_idx = IW'(k);
    end
  end

  assign hit_any   = |match;
  assign all_valid = &valid;

  assign status.need_scan = (cmd_q == fatlb_pkg::CMD_INSERT) && all_valid;
  assign status.scan_done = cmp_valid && (cmp_idx == LAST_IDX);
  assign status.out_free  = !out_valid || out_ready;

  // write port selection
  always_comb begin
    st_we    = 1'b0;
    st_waddr = hit_idx;
    st_wdata = clock_inc;
    fr_we    = 1'b0;
    fr_waddr = free_idx;
    pg_we    = 1'b0;
    pg_waddr = free_idx;
    if (ctl.exec) begin
      case (cmd_q)
        fatlb_pkg::CMD_LOOKUP: begin
          st_we = hit_any;
        end
        fatlb_pkg::CMD_INSERT: begin
          st_we    = !all_valid;
          st_waddr = free_idx;
          fr_we    = !all_valid;
          pg_we    = !all_valid;
        end
        default: ;
      endcase
    end else if (ctl.evict) begin
      // clock already advanced during execute
      st_we    = 1'b1;
      st_waddr = victim;
      st_wdata = access_clock;
      fr_we    = 1'b1;
      fr_waddr = victim;
      pg_we    = 1'b1;
      pg_waddr = victim;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_q   <= in_cmd;
      vpn_q   <= in_vpn;
      frame_q <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (pg_we) page_q[pg_waddr] <= vpn_q;
    if (ctl.evict) evicted_vpn_q <= page_q[victim];
  end

  always_ff @(posedge clk) begin
    if (fr_we) frame_mem[fr_waddr] <= frame_q;
    if (ctl.exec) frame_rd <= frame_mem[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (st_we) stamp_mem[st_waddr] <= st_wdata;
    if (ctl.scan_step && rd_active) stamp_rd <= stamp_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.exec && cmd_q == fatlb_pkg::CMD_FLUSH) begin
      valid <= '0;
    end else if (ctl.exec && cmd_q == fatlb_pkg::CMD_INSERT && !all_valid) begin
      valid[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock    <= '0;
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
    end else begin
      if (ctl.exec && (cmd_q == fatlb_pkg::CMD_LOOKUP || cmd_q == fatlb_pkg::CMD_INSERT))
        access_clock <= clock_inc;
      if (ctl.exec && cmd_q == fatlb_pkg::CMD_LOOKUP) begin
        if (hit_any) hits_total   <= hits_total + fatlb_pkg::COUNT_W'(1);
        else         misses_total <= misses_total + fatlb_pkg::COUNT_W'(1);
      end
      if (ctl.evict) evictions_total <= evictions_total + fatlb_pkg::COUNT_W'(1);
    end
  end

  // victim scan: read one stamp per cycle, compare it in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active <= 1'b0;
      cmp_valid <= 1'b0;
    end else if (ctl.scan_clear) begin
      rd_active <= 1'b1;
      cmp_valid <= 1'b0;
    end else if (ctl.scan_step) begin
      cmp_valid <= rd_active;
      if (rd_active && rd_ptr == LAST_IDX) rd_active <= 1'b0;
    end else begin
      cmp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_clear) begin
      rd_ptr <= '0;
    end else if (ctl.scan_step) begin
      if (rd_active) begin
        rd_ptr  <= rd_ptr + IW'(1);
        cmp_idx <= rd_ptr;
      end
      // strict compare keeps the lowest index on a tie
      if (cmp_valid && (cmp_idx == '0 || stamp_rd < best)) begin
        best   <= stamp_rd;
        victim <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_flag   <= 1'b0;
      evict_flag <= 1'b0;
    end else if (ctl.load_in) begin
      hit_flag   <= 1'b0;
      evict_flag <= 1'b0;
    end else begin
      if (ctl.exec && cmd_q == fatlb_pkg::CMD_LOOKUP && hit_any) hit_flag <= 1'b1;
      if (ctl.evict) evict_flag <= 1'b1;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (ctl.resp)  out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.resp) begin
      out_hit            <= hit_flag;
      out_pfn            <= hit_flag ? frame_rd : '0;
      out_evicted        <= evict_flag;
      out_evicted_vpn    <= evict_flag ? evicted_vpn_q : '0;
      out_hit_count      <= hits_total;
      out_miss_count     <= misses_total;
      out_eviction_count <= evictions_total;
    end
  end

endmodule

>>> rtl/fully_associative_tlb_lru_top.sv
// ----------------------------------------------------------------------------
// fully_associative_tlb_lru_top
// Fully associative translation buffer with least-recently-used replacement.
//
//   channel | dir | beat contents
//   --------+-----+------------------------------------------------------------
//   req     | in  | cmd, vpn, frame_in
//   rsp     | out | hit, frame_out, evicted, evicted_vpn, hit/miss/eviction counts
//
// Lookup, flush and insert into a free slot pass through accept, execute and
// respond; the result is registered onto rsp in the respond step.
// An insert with all slots valid adds a victim scan and a replace step:
// the stamp memory is scanned one entry per cycle through its single read port.
// One command is in flight at a time; req.ready is high only when idle.
// Synchronous reset clears the valid bits, the access clock and the counters.
// A stalled rsp holds the sequencer before it returns to idle.
// ----------------------------------------------------------------------------
module fully_associative_tlb_lru_top #(
  parameter int ENTRIES    = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FRAME_BITS = 20
) (
  input logic         clk,
  input logic         rst,
  fatlb_req_if.sink   req,
  fatlb_rsp_if.source rsp
);

  fatlb_pkg::ctl_cmd_t   ctl;
  fatlb_pkg::dp_status_t status;

  fatlb_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (ctl)
  );

  fatlb_dp #(
    .ENTRIES    (ENTRIES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .in_cmd             (req.cmd),
    .in_vpn             (req.vpn),
    .in_frame           (req.frame_in),
    .ctl                (ctl),
    .status             (status),
    .out_ready          (rsp.ready),
    .out_valid          (rsp.valid),
    .out_hit            (rsp.hit),
    .out_pfn            (rsp.frame_out),
    .out_evicted        (rsp.evicted),
    .out_evicted_vpn    (rsp.evicted_vpn),
    .out_hit_count      (rsp.hit_count),
    .out_miss_count     (rsp.miss_count),
    .out_eviction_count (rsp.eviction_count)
  );

endmodule
